[hdl/assert_macros.svh]
// assertion macros shared by the decoder rtl
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[hdl/irle_pkg.sv]
// types and constants for the interleaved run-length byte decoder
// no dependencies
`timescale 1ns / 1ps

package irle_pkg;

  localparam int OUT_BYTES_DEFAULT = 65536;

  localparam logic [3:0] INTERLEAVE_RESET = 4'd1;
  localparam logic [3:0] INTERLEAVE_MAX   = 4'd9;
  localparam logic [7:0] CMD_RUN_BIT      = 8'h80;
  localparam logic [6:0] COUNT_MASK       = 7'h7f;
  localparam logic [16:0] ADDR_MAX        = 17'h1ffff;

  typedef enum logic [1:0] {
    PH_CMD    = 2'd0,
    PH_LIT    = 2'd1,
    PH_RUNVAL = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LIT      = 2'd0,
    KIND_FILL     = 2'd1,
    KIND_PASS_END = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic [6:0]  repeat_res;
    logic        overflow;
    logic [16:0] out_length;
  } res_t;

endpackage

[hdl/interleaved_rle_byte_decoder_top.sv]
// interleaved run-length byte decoder, single module
// depends on irle_pkg and assert_macros.svh
`timescale 1ns / 1ps

// One compressed byte is taken per clock cycle while in_stall is low. The
// command/literal/run state, pass counter and next write address update at
// the edge that accepts the byte, where any result (literal write, run fill,
// pass end or final length) is registered into the output or skid register.
// A two-entry output buffer (output register plus skid register) lets input
// transfers continue while a result waits; in_stall rises only when both
// entries are full. The user must write interleave through cfg_wr_en and
// cfg_wr_data only while idle, unchecked by the block; out-of-range values select 1.
module interleaved_rle_byte_decoder_top #(
  parameter int OUT_BYTES = irle_pkg::OUT_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] address,
  output logic [7:0]  value,
  output logic [6:0]  repeat_res,
  output logic        overflow,
  output logic [16:0] out_length
);

  `include "assert_macros.svh"

  localparam logic [17:0] OUT_LIMIT = 18'(OUT_BYTES);

  logic [3:0]        interleave;
  irle_pkg::phase_t  phase, phase_next;
  logic [6:0]        remaining, remaining_next;
  logic [3:0]        pass_index, pass_index_next;
  logic [16:0]       next_address, next_address_next;

  irle_pkg::res_t    res;
  logic              res_push;
  irle_pkg::res_t    out_res, skid_res;
  logic              skid_valid;

  logic              in_accept;
  logic              out_pop;

  logic [6:0]        run_cnt;
  logic [6:0]        run_cnt_m1;
  logic [10:0]       span_last;
  logic [10:0]       span_full;
  logic [17:0]       last_addr;
  logic [17:0]       adv_lit;
  logic [17:0]       adv_run;
  logic [3:0]        pass_inc;
  logic [17:0]       addr_p1;
  logic [17:0]       len_raw;
  logic [17:0]       len_clamp;

  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = skid_valid;

  // shared arithmetic
  assign run_cnt    = remaining;
  assign run_cnt_m1 = run_cnt - 7'd1;
  assign span_last  = 11'(run_cnt_m1) * 11'(interleave);
  assign span_full  = 11'(run_cnt) * 11'(interleave);
  assign last_addr  = 18'(next_address) + 18'(span_last);
  assign adv_lit    = 18'(next_address) + 18'(interleave);
  assign adv_run    = 18'(next_address) + 18'(span_full);
  assign pass_inc   = pass_index + 4'd1;
  assign addr_p1    = 18'(next_address) + 18'd1;
  assign len_raw    = (addr_p1 > 18'(interleave)) ? addr_p1 - 18'(interleave) : 18'd0;
  assign len_clamp  = (len_raw > OUT_LIMIT) ? OUT_LIMIT : len_raw;

  // next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      irle_pkg::PH_CMD: begin
        if (in_byte == 8'd0) begin
          if (pass_inc >= interleave) begin
            phase_next = irle_pkg::PH_DONE;
          end
        end else if ((in_byte & irle_pkg::CMD_RUN_BIT) == 8'd0) begin
          phase_next = irle_pkg::PH_LIT;
        end else begin
          phase_next = irle_pkg::PH_RUNVAL;
        end
      end
      irle_pkg::PH_LIT: begin
        if (remaining == 7'd1) begin
          phase_next = irle_pkg::PH_CMD;
        end
      end
      irle_pkg::PH_RUNVAL: phase_next = irle_pkg::PH_CMD;
      irle_pkg::PH_DONE:   phase_next = irle_pkg::PH_DONE;
      default:             phase_next = irle_pkg::PH_CMD;
    endcase
  end

  // result and datapath registers
  always_comb begin
    res               = '0;
    res.kind          = irle_pkg::KIND_LIT;
    res_push          = 1'b0;
    remaining_next    = remaining;
    pass_index_next   = pass_index;
    next_address_next = next_address;
    unique case (phase)
      irle_pkg::PH_CMD: begin
        if (in_byte == 8'd0) begin
          pass_index_next = pass_inc;
          res_push        = 1'b1;
          if (pass_inc >= interleave) begin
            res.kind       = irle_pkg::KIND_DONE;
            res.out_length = len_clamp[16:0];
          end else begin
            res.kind          = irle_pkg::KIND_PASS_END;
            next_address_next = 17'(pass_inc);
          end
        end else begin
          remaining_next = in_byte[6:0] & irle_pkg::COUNT_MASK;
        end
      end
      irle_pkg::PH_LIT: begin
        res_push          = 1'b1;
        res.kind          = irle_pkg::KIND_LIT;
        res.address       = next_address[15:0];
        res.value         = in_byte;
        res.repeat_res    = 7'd1;
        res.overflow      = 18'(next_address) >= OUT_LIMIT;
        remaining_next    = remaining - 7'd1;
        next_address_next = adv_lit[17] ? irle_pkg::ADDR_MAX : adv_lit[16:0];
      end
      irle_pkg::PH_RUNVAL: begin
        remaining_next = 7'd0;
        // an empty run swallows its value byte silently
        if (run_cnt != 7'd0) begin
          res_push          = 1'b1;
          res.kind          = irle_pkg::KIND_FILL;
          res.address       = next_address[15:0];
          res.value         = in_byte;
          res.repeat_res    = run_cnt;
          res.overflow      = last_addr >= OUT_LIMIT;
          next_address_next = adv_run[17] ? irle_pkg::ADDR_MAX : adv_run[16:0];
        end
      end
      irle_pkg::PH_DONE: begin
        res_push = 1'b0;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interleave   <= irle_pkg::INTERLEAVE_RESET;
      phase        <= irle_pkg::PH_CMD;
      remaining    <= 7'd0;
      pass_index   <= 4'd0;
      next_address <= 17'd0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_wr_data == 4'd0 || cfg_wr_data > irle_pkg::INTERLEAVE_MAX) begin
          interleave <= irle_pkg::INTERLEAVE_RESET;
        end else begin
          interleave <= cfg_wr_data;
        end
      end
      if (in_accept) begin
        phase        <= phase_next;
        remaining    <= remaining_next;
        pass_index   <= pass_index_next;
        next_address <= next_address_next;
      end
    end
  end

  // two-entry output buffer; skid only fills while the output register holds
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept && res_push;
        end
      end else if (in_accept && res_push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_accept && res_push) begin
        out_res <= res;
      end
    end else if (in_accept && res_push) begin
      skid_res <= res;
    end
  end

  assign kind       = out_res.kind;
  assign address    = out_res.address;
  assign value      = out_res.value;
  assign repeat_res = out_res.repeat_res;
  assign overflow   = out_res.overflow;
  assign out_length = out_res.out_length;

  `ASSERT_IMPL(a_skid_needs_out, skid_valid, out_valid, "skid entry held without output entry")
  `ASSERT_NEXT(a_done_sticks, phase == irle_pkg::PH_DONE, phase == irle_pkg::PH_DONE, "decoder left done phase")
  `ASSERT_IMPL(a_done_silent, in_accept && phase == irle_pkg::PH_DONE, !res_push, "result after final pass")
  `ASSERT_IMPL(a_lit_single, out_valid && kind == irle_pkg::KIND_LIT, repeat_res == 7'd1, "literal write with count other than one")
  `ASSERT_NEXT(a_final_done, in_accept && res_push && res.kind == irle_pkg::KIND_DONE, phase == irle_pkg::PH_DONE, "final length without done phase")

endmodule
